>>> rtl/assert_macros.svh
// Assertion macros shared by the splitter RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication: whenever ante holds, cons holds on that edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons holds on the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/dfs_pkg.sv
// Shared constants and types for the delimiter field splitter.
package dfs_pkg;

	localparam int MAX_DELIM = 8;
	localparam int BYTE_W = 8;
	localparam int LEN_W = 4;
	localparam int POS_W = 16;
	localparam int IDX_W = 8;
	localparam int DELIM_W = MAX_DELIM * BYTE_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = DELIM_W;

	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [DELIM_W-1:0] DELIM_RESET = DELIM_W'(44);
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);
	localparam logic [IDX_W-1:0] FRAGS_RESET = IDX_W'(255);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DELIM_BYTES = 2'd0,
		CFG_DELIM_LEN   = 2'd1,
		CFG_MAX_FRAGS   = 2'd2
	} cfg_idx_t;

	typedef logic [MAX_DELIM-1:0][BYTE_W-1:0] win_t;

	// Delimiter as seen by the matcher, length already clamped to 1..MAX_DELIM
	typedef struct packed {
		logic [DELIM_W-1:0] bytes;
		logic [LEN_W-1:0]   len;
	} delim_t;

	typedef struct packed {
		logic             has_fragment;
		logic [IDX_W-1:0] frag_index;
		logic [POS_W-1:0] frag_start;
		logic [POS_W-1:0] frag_end;
		logic             done_res;
		logic             is_error;
		logic [IDX_W-1:0] split_count;
		logic [POS_W-1:0] total_count;
	} res_t;

endpackage

>>> rtl/dfs_if.sv
// Valid/ready channel interfaces for string bytes and split records.
interface dfs_byte_if
	import dfs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

interface dfs_rec_if
	import dfs_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             has_fragment;
	logic [IDX_W-1:0] frag_index;
	logic [POS_W-1:0] frag_start;
	logic [POS_W-1:0] frag_end;
	logic             done_res;
	logic             is_error;
	logic [IDX_W-1:0] split_count;
	logic [POS_W-1:0] total_count;

	modport source (output valid, output has_fragment, output frag_index, output frag_start,
		output frag_end, output done_res, output is_error, output split_count,
		output total_count, input ready);
	modport sink (input valid, input has_fragment, input frag_index, input frag_start,
		input frag_end, input done_res, input is_error, input split_count,
		input total_count, output ready);
endinterface

>>> rtl/dfs_match.sv
// Parallel compare of the byte window against the configured delimiter.
module dfs_match
	import dfs_pkg::*;
(
	input  win_t             win,
	input  delim_t           delim,
	input  logic [POS_W-1:0] avail,
	output logic             hit
);

	logic [MAX_DELIM-1:0] lane_ok;

	// Check each window lane; the newest byte pairs with the last delimiter byte
	always_comb begin
		for (int k = 0; k < MAX_DELIM; k++) begin
			logic [LEN_W-1:0]  j;
			logic [BYTE_W-1:0] d;
			j = delim.len - LEN_W'(k) - LEN_W'(1);
			d = delim.bytes[BYTE_W*j[$clog2(MAX_DELIM)-1:0] +: BYTE_W];
			if (LEN_W'(k) >= delim.len) begin
				lane_ok[k] = 1'b1;
			end else begin
				lane_ok[k] = (d != '0) && (d == win[k]);
			end
		end
	end

	// Require enough bytes since the last match, then all lanes
	assign hit = (avail >= POS_W'(delim.len)) && (&lane_ok);

endmodule

>>> rtl/delimiter_field_splitter.sv
// Top level of the delimiter field splitter.
// Takes one string byte per beat on chars (a zero byte ends the string) and
// accepts a new byte every clock cycle: the window compare, the counters and
// the record fields are all settled in the cycle a byte is accepted, and the
// record lands in a single output register in the following cycle. That register
// frees as soon as records takes its beat, so a full rate stream needs only
// records.ready held high; a stalled output register holds chars off. A match
// of the delimiter (leftmost, non-overlapping) yields a fragment record until
// max_frags fragments were reported; the terminator always yields the final
// record with the counts, then clears the string state. Configuration must be
// written through cfg_we/cfg_index/cfg_data between strings only; the block does not enforce it.
module delimiter_field_splitter
	import dfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	dfs_byte_if.sink              chars,
	dfs_rec_if.source             records,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

	// Configuration registers
	logic [DELIM_W-1:0] delim_bytes_q;
	logic [LEN_W-1:0]   delim_len_q;
	logic [IDX_W-1:0]   max_frags_q;

	// String state
	win_t             win_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] search_q;
	logic [POS_W-1:0] frag_start_q;
	logic [IDX_W-1:0] frag_idx_q;
	logic             split_fin_q;
	logic [POS_W-1:0] delim_cnt_q;

	// Output register
	logic res_valid_q;
	res_t res_q;

	logic             accept;
	logic             is_term;
	win_t             win_n;
	logic [POS_W-1:0] pos_n;
	logic [POS_W-1:0] avail;
	delim_t           delim;
	logic             hit;
	logic             limited;
	logic [POS_W:0]   total_raw;
	logic [IDX_W-1:0] frag_idx_inc;
	logic             emit;
	res_t             res_n;

	assign chars.ready = !res_valid_q || records.ready;
	assign accept = chars.valid && chars.ready;
	assign is_term = (chars.char_byte == '0);

	// Clamp delimiter length to 1..MAX_DELIM
	always_comb begin
		delim.bytes = delim_bytes_q;
		if (delim_len_q == '0) begin
			delim.len = LEN_W'(1);
		end else if (delim_len_q > LEN_W'(MAX_DELIM)) begin
			delim.len = LEN_W'(MAX_DELIM);
		end else begin
			delim.len = delim_len_q;
		end
	end

	// Shift the new byte into the window and advance the position
	always_comb begin
		win_n[0] = chars.char_byte;
		for (int k = 1; k < MAX_DELIM; k++) begin
			win_n[k] = win_q[k-1];
		end
	end
	assign pos_n = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
	assign avail = pos_n - search_q;

	dfs_match u_match (
		.win   (win_n),
		.delim (delim),
		.avail (avail),
		.hit   (hit)
	);

	assign limited = split_fin_q || (frag_idx_q >= max_frags_q);
	assign frag_idx_inc = frag_idx_q + IDX_W'(1);
	assign total_raw = {1'b0, delim_cnt_q} + (POS_W+1)'(pos_q > search_q);

	// Build the record for this byte
	always_comb begin
		res_n = '0;
		emit = 1'b0;
		if (is_term) begin
			emit = 1'b1;
			res_n.done_res = 1'b1;
			if (pos_q == '0) begin
				res_n.is_error = 1'b1;
			end else begin
				if (!limited) begin
					res_n.has_fragment = 1'b1;
					res_n.frag_index = frag_idx_q;
					res_n.frag_start = frag_start_q;
					res_n.frag_end = pos_q;
					res_n.split_count = frag_idx_inc;
				end else begin
					res_n.split_count = max_frags_q;
				end
				res_n.total_count = total_raw[POS_W] ? POS_MAX : total_raw[POS_W-1:0];
			end
		end else if (hit && !limited) begin
			emit = 1'b1;
			res_n.has_fragment = 1'b1;
			res_n.frag_index = frag_idx_q;
			res_n.frag_start = frag_start_q;
			res_n.frag_end = pos_n - POS_W'(delim.len);
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_bytes_q <= DELIM_RESET;
			delim_len_q <= LEN_RESET;
			max_frags_q <= FRAGS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DELIM_BYTES: delim_bytes_q <= cfg_data[DELIM_W-1:0];
				CFG_DELIM_LEN:   delim_len_q <= cfg_data[LEN_W-1:0];
				CFG_MAX_FRAGS:   max_frags_q <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance string state on each accepted byte; clear on the terminator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			pos_q <= '0;
			search_q <= '0;
			frag_start_q <= '0;
			frag_idx_q <= '0;
			split_fin_q <= 1'b0;
			delim_cnt_q <= '0;
		end else if (accept) begin
			if (is_term) begin
				win_q <= '0;
				pos_q <= '0;
				search_q <= '0;
				frag_start_q <= '0;
				frag_idx_q <= '0;
				split_fin_q <= 1'b0;
				delim_cnt_q <= '0;
			end else begin
				win_q <= win_n;
				pos_q <= pos_n;
				if (hit) begin
					if (delim_cnt_q != POS_MAX) begin
						delim_cnt_q <= delim_cnt_q + POS_W'(1);
					end
					search_q <= pos_n;
					if (limited) begin
						split_fin_q <= 1'b1;
					end else begin
						frag_start_q <= pos_n;
						frag_idx_q <= frag_idx_inc;
						if (frag_idx_inc >= max_frags_q) begin
							split_fin_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	// Hold the record until records takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && emit) begin
			res_valid_q <= 1'b1;
		end else if (records.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_q <= res_n;
		end
	end

	assign records.valid = res_valid_q;
	assign records.has_fragment = res_q.has_fragment;
	assign records.frag_index = res_q.frag_index;
	assign records.frag_start = res_q.frag_start;
	assign records.frag_end = res_q.frag_end;
	assign records.done_res = res_q.done_res;
	assign records.is_error = res_q.is_error;
	assign records.split_count = res_q.split_count;
	assign records.total_count = res_q.total_count;

	`ASSERT_NEXT(a_term_clears, clk, arst_n, accept && is_term, pos_q == '0 && frag_idx_q == '0 && !split_fin_q)
	`ASSERT_NEXT(a_byte_advances, clk, arst_n, accept && !is_term, pos_q != '0)
	`ASSERT_IMPLIES(a_offsets_ordered, clk, arst_n, 1'b1, frag_start_q <= search_q && search_q <= pos_q)
	`ASSERT_IMPLIES(a_error_empty, clk, arst_n, res_valid_q && res_q.is_error, !res_q.has_fragment && res_q.total_count == '0 && res_q.done_res)
	`ASSERT_IMPLIES(a_frag_span, clk, arst_n, res_valid_q && res_q.has_fragment, res_q.frag_start <= res_q.frag_end)

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the delimiter field splitter: directed table, a long delimiter run, random.
module testbench;
	import dfs_pkg::*;

	localparam int CLK_HALF = 10;
	localparam int RESET_CYCLES = 4;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_BYTES = 1400;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DIR_ROWS = 32;
	localparam logic [BYTE_W-1:0] COMMA = 8'h2C;

	typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		cfg_idx_t              reg_idx;
		logic [CFG_DATA_W-1:0] value;
		bit                    typed;
		res_t                  rec;
	} stim_row_t;

	typedef logic [BYTE_W-1:0] byte_q_t[$];

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dfs_byte_if chars_if();
	dfs_rec_if  recs_if();

	delimiter_field_splitter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars_if),
		.records   (recs_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the configuration registers
	logic [DELIM_W-1:0] sh_delim;
	logic [LEN_W-1:0]   sh_len;
	logic [IDX_W-1:0]   sh_frags;

	// Shadow string state of the splitter
	logic [BYTE_W-1:0] win_bytes [MAX_DELIM];
	int                str_pos;
	int                scan_from;
	int                frag_from;
	int                frag_num;
	bit                split_done;
	int                delim_seen;

	res_t pending_recs[$];
	int   errors = 0;
	int   sent_bytes = 0;
	int   cycle_cnt = 0;
	bit   src_idle = 1'b1;
	bit   snk_idle = 1'b1;
	bit   hold_req = 1'b0;

	stim_row_t dir_rows [DIR_ROWS];

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// End the run if it hangs
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("** delimiter_field_splitter: FAILED **");
			$finish;
		end
	end

	function automatic int clamp_len(input logic [LEN_W-1:0] l);
		if (l == '0) return 1;
		if (l > MAX_DELIM) return MAX_DELIM;
		return int'(l);
	endfunction

	function automatic void clear_string();
		foreach (win_bytes[j]) win_bytes[j] = '0;
		str_pos = 0;
		scan_from = 0;
		frag_from = 0;
		frag_num = 0;
		split_done = 1'b0;
		delim_seen = 0;
	endfunction

	// Advance the shadow splitter by one byte; return 1 when a record is due
	function automatic bit split_step(input logic [BYTE_W-1:0] b, output res_t r);
		int                len;
		int                total;
		int                j;
		bit                hit;
		logic [BYTE_W-1:0] d;
		r = '0;
		len = clamp_len(sh_len);
		if (b == '0) begin
			r.done_res = 1'b1;
			if (str_pos == 0) begin
				r.is_error = 1'b1;
			end else begin
				total = delim_seen + ((str_pos > scan_from) ? 1 : 0);
				if (!split_done && frag_num < int'(sh_frags)) begin
					r.has_fragment = 1'b1;
					r.frag_index = IDX_W'(frag_num);
					r.frag_start = POS_W'(frag_from);
					r.frag_end = POS_W'(str_pos);
					r.split_count = IDX_W'(frag_num + 1);
				end else begin
					r.split_count = sh_frags;
				end
				r.total_count = (total > int'(POS_MAX)) ? POS_MAX : POS_W'(total);
			end
			clear_string();
			return 1'b1;
		end
		// shift the window, newest byte in entry 0
		for (j = MAX_DELIM - 1; j > 0; j--) win_bytes[j] = win_bytes[j-1];
		win_bytes[0] = b;
		if (str_pos < int'(POS_MAX)) str_pos++;
		hit = (str_pos - scan_from >= len);
		for (j = 0; j < len; j++) begin
			d = sh_delim[BYTE_W*(len-1-j) +: BYTE_W];
			if (d == '0 || d != win_bytes[j]) hit = 1'b0;
		end
		if (!hit) return 1'b0;
		if (delim_seen < int'(POS_MAX)) delim_seen++;
		scan_from = str_pos;
		if (split_done || frag_num >= int'(sh_frags)) begin
			split_done = 1'b1;
			return 1'b0;
		end
		r.has_fragment = 1'b1;
		r.frag_index = IDX_W'(frag_num);
		r.frag_start = POS_W'(frag_from);
		r.frag_end = POS_W'(str_pos - len);
		frag_from = str_pos;
		frag_num++;
		if (frag_num >= int'(sh_frags)) split_done = 1'b1;
		return 1'b1;
	endfunction

	// Mostly no gap, some short ones, a few long ones
	function automatic int idle_gap(input bit enabled);
		int r;
		if (!enabled) return 0;
		r = $urandom_range(0, 99);
		if (r < 80) return 0;
		if (r < 96) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [BYTE_W-1:0] nonzero(input logic [BYTE_W-1:0] b);
		return (b == '0) ? BYTE_W'($urandom_range(1, 255)) : b;
	endfunction

	function automatic res_t make_rec(input bit has, input int idx, input int fstart,
		input int fend, input bit done, input bit err, input int split, input int total);
		res_t r;
		r.has_fragment = has;
		r.frag_index = IDX_W'(idx);
		r.frag_start = POS_W'(fstart);
		r.frag_end = POS_W'(fend);
		r.done_res = done;
		r.is_error = err;
		r.split_count = IDX_W'(split);
		r.total_count = POS_W'(total);
		return r;
	endfunction

	function automatic stim_row_t byte_row(input logic [BYTE_W-1:0] b);
		return '{kind: ROW_BYTE, reg_idx: CFG_DELIM_BYTES, value: CFG_DATA_W'(b), typed: 1'b0,
			rec: '0};
	endfunction

	function automatic stim_row_t typed_row(input logic [BYTE_W-1:0] b, input res_t rec);
		return '{kind: ROW_BYTE, reg_idx: CFG_DELIM_BYTES, value: CFG_DATA_W'(b), typed: 1'b1,
			rec: rec};
	endfunction

	function automatic stim_row_t reg_row(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
		return '{kind: ROW_REG, reg_idx: idx, value: v, typed: 1'b0, rec: '0};
	endfunction

	// Pick a content byte: half from the delimiter itself, to build near misses
	function automatic logic [BYTE_W-1:0] content_byte(input int len);
		if ($urandom_range(0, 1) == 0)
			return nonzero(sh_delim[BYTE_W*$urandom_range(0, len-1) +: BYTE_W]);
		return BYTE_W'($urandom_range(1, 255));
	endfunction

	// Build one string without its terminator: mostly fields joined by the delimiter
	function automatic byte_q_t make_string();
		byte_q_t s;
		int      len;
		int      mode;
		int      nfrag;
		int      f;
		int      j;
		len = clamp_len(sh_len);
		mode = $urandom_range(0, 99);
		if (mode < 8) return s;
		if (mode < 22) begin
			repeat ($urandom_range(1, 20)) s.push_back(content_byte(len));
			return s;
		end
		nfrag = $urandom_range(1, 6);
		for (f = 0; f < nfrag; f++) begin
			repeat ($urandom_range(0, 5)) s.push_back(content_byte(len));
			if (f < nfrag - 1 || $urandom_range(0, 3) == 0)
				for (j = 0; j < len; j++) s.push_back(nonzero(sh_delim[BYTE_W*j +: BYTE_W]));
		end
		return s;
	endfunction

	// Offer one beat on chars and record what the splitter owes for it
	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed, input res_t typed_rec);
		int   gap;
		bit   made;
		res_t r;
		gap = idle_gap(src_idle);
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.char_byte <= b;
		@(posedge clk);
		while (chars_if.ready !== 1'b1) @(posedge clk);
		made = split_step(b, r);
		if (made || typed) pending_recs.push_back(typed ? typed_rec : r);
		sent_bytes++;
	endtask

	task automatic send_string(input byte_q_t s);
		foreach (s[i]) send_byte(s[i], 1'b0, '0);
		send_byte('0, 1'b0, '0);
	endtask

	// Drain the splitter, then write one register
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		chars_if.valid <= 1'b0;
		while (pending_recs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DELIM_BYTES: sh_delim = data;
			CFG_DELIM_LEN:   sh_len = data[LEN_W-1:0];
			CFG_MAX_FRAGS:   sh_frags = data[IDX_W-1:0];
			default: ;
		endcase
	endtask

	// Draw a new delimiter, length and fragment limit
	task automatic random_setup();
		logic [DELIM_W-1:0] d;
		logic [LEN_W-1:0]   l;
		int                 r;
		int                 len;
		int                 j;
		d = {$urandom, $urandom};
		r = $urandom_range(0, 99);
		if (r < 6) l = '0;
		else if (r < 12) l = LEN_W'($urandom_range(9, 15));
		else if (r < 50) l = LEN_W'($urandom_range(1, 2));
		else l = LEN_W'($urandom_range(1, 8));
		len = clamp_len(l);
		for (j = 0; j < len; j++) begin
			// repeated bytes give overlapping candidates
			if ($urandom_range(0, 3) == 0)
				d[BYTE_W*j +: BYTE_W] = ($urandom_range(0, 1) == 0) ? COMMA : 8'h61;
			d[BYTE_W*j +: BYTE_W] = nonzero(d[BYTE_W*j +: BYTE_W]);
		end
		if ($urandom_range(0, 11) == 0) d[BYTE_W*$urandom_range(0, len-1) +: BYTE_W] = '0;
		write_reg(CFG_DELIM_BYTES, d);
		write_reg(CFG_DELIM_LEN, CFG_DATA_W'(l));
		r = $urandom_range(0, 99);
		if (r < 20) write_reg(CFG_MAX_FRAGS, CFG_DATA_W'(255));
		else if (r < 28) write_reg(CFG_MAX_FRAGS, '0);
		else if (r < 40) write_reg(CFG_MAX_FRAGS, CFG_DATA_W'($urandom_range(1, 255)));
		else write_reg(CFG_MAX_FRAGS, CFG_DATA_W'($urandom_range(1, 5)));
	endtask

	task automatic check_field(input string name, input logic [POS_W-1:0] want,
		input logic [POS_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Compare one record beat with the oldest one owed
	task automatic check_record();
		res_t got;
		res_t want;
		got = {recs_if.has_fragment, recs_if.frag_index, recs_if.frag_start, recs_if.frag_end,
			recs_if.done_res, recs_if.is_error, recs_if.split_count, recs_if.total_count};
		if (pending_recs.size() == 0) begin
			$display("%0t ns: record expected none, got %h", $time, got);
			errors++;
			return;
		end
		want = pending_recs.pop_front();
		check_field("has_fragment", POS_W'(want.has_fragment), POS_W'(got.has_fragment));
		check_field("frag_index", POS_W'(want.frag_index), POS_W'(got.frag_index));
		check_field("frag_start", want.frag_start, got.frag_start);
		check_field("frag_end", want.frag_end, got.frag_end);
		check_field("done_res", POS_W'(want.done_res), POS_W'(got.done_res));
		check_field("is_error", POS_W'(want.is_error), POS_W'(got.is_error));
		check_field("split_count", POS_W'(want.split_count), POS_W'(got.split_count));
		check_field("total_count", want.total_count, got.total_count);
	endtask

	// Record side: take beats, stall at random, hold off long on request
	initial begin
		int stall_left;
		stall_left = 0;
		recs_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (recs_if.valid === 1'b1 && recs_if.ready === 1'b1) check_record();
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0) begin
				stall_left = idle_gap(snk_idle);
			end
			if (stall_left > 0) begin
				stall_left--;
				recs_if.ready <= 1'b0;
			end else begin
				recs_if.ready <= 1'b1;
			end
		end
	end

	// Stimulus
	initial begin
		byte_q_t s;
		int      base;
		int      phase;
		int      i;
		arst_n = 1'b0;
		chars_if.valid <= 1'b0;
		chars_if.char_byte <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_DELIM_BYTES;
		cfg_data <= '0;
		sh_delim = DELIM_RESET;
		sh_len = LEN_RESET;
		sh_frags = FRAGS_RESET;
		clear_string();

		dir_rows = '{
			typed_row(8'h00, make_rec(0, 0, 0, 0, 1, 1, 0, 0)),
			byte_row(8'h61),
			typed_row(COMMA, make_rec(1, 0, 0, 1, 0, 0, 0, 0)),
			byte_row(COMMA),
			byte_row(8'h00),
			reg_row(CFG_MAX_FRAGS, 1),
			byte_row(8'h78),
			typed_row(COMMA, make_rec(1, 0, 0, 1, 0, 0, 0, 0)),
			byte_row(8'h79),
			byte_row(COMMA),
			typed_row(8'h00, make_rec(0, 0, 0, 0, 1, 0, 1, 2)),
			reg_row(CFG_MAX_FRAGS, 0),
			reg_row(CFG_DELIM_LEN, 0),
			byte_row(COMMA),
			typed_row(8'h00, make_rec(0, 0, 0, 0, 1, 0, 0, 1)),
			reg_row(CFG_DELIM_BYTES, 64'h0102_0304_0506_0708),
			reg_row(CFG_DELIM_LEN, 15),
			reg_row(CFG_MAX_FRAGS, 255),
			byte_row(8'h08),
			byte_row(8'h07),
			byte_row(8'h06),
			byte_row(8'h05),
			byte_row(8'h04),
			byte_row(8'h03),
			byte_row(8'h02),
			typed_row(8'h01, make_rec(1, 0, 0, 0, 0, 0, 0, 0)),
			byte_row(8'hFF),
			typed_row(8'h00, make_rec(1, 1, 8, 9, 1, 0, 2, 2)),
			reg_row(CFG_DELIM_BYTES, 64'h2C00),
			reg_row(CFG_DELIM_LEN, 2),
			byte_row(COMMA),
			typed_row(8'h00, make_rec(1, 0, 0, 1, 1, 0, 1, 1))
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_REG)
				write_reg(dir_rows[k].reg_idx, dir_rows[k].value);
			else
				send_byte(dir_rows[k].value[BYTE_W-1:0], dir_rows[k].typed, dir_rows[k].rec);
		end

		// Long delimiter run: the fragment index reaches its top value, then the limit
		src_idle = 1'b0;
		write_reg(CFG_DELIM_BYTES, CFG_DATA_W'(COMMA));
		write_reg(CFG_DELIM_LEN, 1);
		write_reg(CFG_MAX_FRAGS, 255);
		s = {};
		for (i = 0; i < 300; i++) s.push_back(COMMA);
		send_string(s);

		// Random phases, each under a fresh configuration
		base = sent_bytes;
		phase = 0;
		while (sent_bytes - base < RANDOM_BYTES) begin
			random_setup();
			src_idle = ($urandom_range(0, 3) != 0);
			snk_idle = ($urandom_range(0, 3) != 0);
			if (phase == 2) begin
				src_idle = 1'b0;
				hold_req = 1'b1;
			end
			repeat ($urandom_range(3, 8)) send_string(make_string());
			phase++;
		end

		// Drain and report
		chars_if.valid <= 1'b0;
		while (pending_recs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES * 4) @(posedge clk);
		if (errors == 0)
			$display("** delimiter_field_splitter: PASSED **");
		else
			$display("** delimiter_field_splitter: FAILED **");
		$finish;
	end

endmodule
